// ===== rtl/zcwe_pkg.sv =====
// Shared types and constants of the zero-crossing window edge core.
// No dependencies; imported by the window datapath and the top level.
package zcwe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_WINDOW = 7;
  localparam int MAX_ROWS   = 4096;
  localparam int BIAS       = 128;
  localparam int NCH        = 3;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = NCH * CHAN_W;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_ROWS) + 1;
  localparam int LIN_W      = COL_W + ROW_W;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int HALF_W     = $clog2(MAX_WINDOW / 2 + 1);
  localparam int CTR        = MAX_WINDOW / 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;
  localparam int WIN_REG_W  = 3;
  localparam int THR_W      = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_WINDOW = 3'd2,
    CFG_THRESH = 3'd3,
    CFG_COLOR  = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NCH-1:0]   pix_t;

  // column read request, travels with the RAM read into the window stage
  typedef struct packed {
    logic                             rd;
    logic                             out;
    logic                             eof;
    logic [COL_W-1:0]                 ocol;
    logic [MAX_WINDOW-1:0]            rowok;
    logic [MAX_WINDOW-1:0]            fwd;
    logic [MAX_WINDOW-1:0][SLOT_W-1:0] slot;
    pix_t                             fwd_pix;
  } col_req_t;

  // output request at the window compare stage
  typedef struct packed {
    logic             out;
    logic             eof;
    logic [COL_W-1:0] ocol;
  } win_req_t;

  typedef struct packed {
    logic [THR_W-1:0]  thresh;
    logic              color;
    logic [HALF_W-1:0] half;
    logic [COL_W:0]    width;
  } dp_cfg_t;

endpackage

// ===== rtl/zcwe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for each row of the line store.
module zcwe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/zcwe_window.sv =====
// Window datapath: per-column min/max of the rows read back, the column
// shift window, and the final extreme compare. Depends on zcwe_pkg.
module zcwe_window (
  input  logic              clk,
  input  logic              adv,
  input  zcwe_pkg::col_req_t req,
  input  zcwe_pkg::pix_t    ram_q [zcwe_pkg::MAX_WINDOW],
  input  zcwe_pkg::dp_cfg_t cfg,
  input  logic [zcwe_pkg::COL_W-1:0] ocol,
  output zcwe_pkg::pix_t    result
);
  import zcwe_pkg::*;

  chan_t cmin_w [MAX_WINDOW][NCH];
  chan_t cmax_w [MAX_WINDOW][NCH];
  pix_t  ctr_w  [MAX_WINDOW];

  pix_t  row_v  [MAX_WINDOW];
  chan_t cmin_n [NCH];
  chan_t cmax_n [NCH];

  // column reduce over the rows of the window
  always_comb begin
    for (int o = 0; o < MAX_WINDOW; o++) begin
      if (!req.rowok[o]) begin
        row_v[o] = '0;
      end else if (req.fwd[o]) begin
        row_v[o] = req.fwd_pix;
      end else begin
        row_v[o] = ram_q[req.slot[o]];
      end
    end
    for (int ch = 0; ch < NCH; ch++) begin
      cmin_n[ch] = '1;
      cmax_n[ch] = '0;
      for (int o = 0; o < MAX_WINDOW; o++) begin
        if (o >= CTR - int'(cfg.half) && o <= CTR + int'(cfg.half)) begin
          if (row_v[o][ch] < cmin_n[ch]) cmin_n[ch] = row_v[o][ch];
          if (row_v[o][ch] > cmax_n[ch]) cmax_n[ch] = row_v[o][ch];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && req.rd) begin
      for (int j = 0; j < MAX_WINDOW - 1; j++) begin
        cmin_w[j] <= cmin_w[j+1];
        cmax_w[j] <= cmax_w[j+1];
        ctr_w[j]  <= ctr_w[j+1];
      end
      cmin_w[MAX_WINDOW-1] <= cmin_n;
      cmax_w[MAX_WINDOW-1] <= cmax_n;
      ctr_w[MAX_WINDOW-1]  <= row_v[CTR];
    end
  end

  logic signed [COL_W+2:0]  c_pos [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]    col_in;
  logic [MAX_WINDOW-1:0]    col_ok;
  chan_t                    lo;
  chan_t                    hi;
  logic [SLOT_W-1:0]        cidx;
  pix_t                     ctr;
  logic                     lo_ok;
  logic                     hi_ok;

  // newest column sits at the top; columns outside the image count as zero
  always_comb begin
    cidx = SLOT_W'(MAX_WINDOW - 1) - SLOT_W'(cfg.half);
    ctr  = ctr_w[cidx];
    for (int j = 0; j < MAX_WINDOW; j++) begin
      c_pos[j]  = $signed({3'b000, ocol})
                + $signed((COL_W+3)'(j + int'(cfg.half) - (MAX_WINDOW - 1)));
      col_in[j] = (j >= MAX_WINDOW - 1 - 2 * int'(cfg.half));
      col_ok[j] = (c_pos[j] >= 0) && (c_pos[j] < $signed({2'b00, cfg.width}));
    end
    result = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      lo = '1;
      hi = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if (col_in[j]) begin
          if (col_ok[j]) begin
            if (cmin_w[j][ch] < lo) lo = cmin_w[j][ch];
            if (cmax_w[j][ch] > hi) hi = cmax_w[j][ch];
          end else begin
            lo = '0;
          end
        end
      end
      lo_ok = ({2'b00, lo} + {2'b00, cfg.thresh}) < 10'(BIAS);
      hi_ok = {2'b00, hi} > (10'(BIAS) + {2'b00, cfg.thresh});
      if (lo_ok && hi_ok && (ch == 0 || cfg.color)) begin
        result[ch] = ctr[ch];
      end
    end
  end

endmodule

// ===== rtl/zero_crossing_window_edge_core.sv =====
// Zero-crossing edge core: counters, line store rows and the pipeline control.
// Depends on zcwe_pkg, zcwe_ram and zcwe_window.
//
//   port group   dir   word
//   in_*         in    operation, sample_r, sample_g, sample_b
//   out_*        out   edge_r, edge_g, edge_b, end_of_frame
//   cfg_*        in    cfg_index, cfg_data (write only)
//
// One word per cycle unless stalled; results pass s1, s2 and the output register.
// After the last pixel of a small frame the input stalls while column reads are
// still owed by the window (at most half the window side).
// The input stalls in the cycle after each configuration write.
// Reset clears counters and pipeline control; line store contents stay.
// Output stall freezes the pipeline only while the compare stage holds a result.
module zero_crossing_window_edge_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic [zcwe_pkg::CHAN_W-1:0]   sample_r,
  input  logic [zcwe_pkg::CHAN_W-1:0]   sample_g,
  input  logic [zcwe_pkg::CHAN_W-1:0]   sample_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [zcwe_pkg::CHAN_W-1:0]   edge_r,
  output logic [zcwe_pkg::CHAN_W-1:0]   edge_g,
  output logic [zcwe_pkg::CHAN_W-1:0]   edge_b,
  output logic                          end_of_frame,
  input  logic                          cfg_write,
  input  logic [zcwe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [zcwe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import zcwe_pkg::*;

  // configuration
  logic [COL_W:0]     cfg_width;
  logic [ROW_W-1:0]   cfg_height;
  logic [WIN_REG_W-1:0] cfg_win;
  logic [THR_W-1:0]   cfg_thresh;
  logic               cfg_color;
  logic               settle;

  logic [COL_W:0]     w;
  logic [ROW_W-1:0]   h;
  logic [WIN_REG_W-1:0] kk;
  logic [HALF_W-1:0]  half;
  logic [LIN_W-1:0]   hw;
  logic [LIN_W-1:0]   lag;
  logic [LIN_W-1:0]   total_m1;

  // counters
  logic [COL_W-1:0]   in_col;
  logic [ROW_W-1:0]   in_row;
  logic [SLOT_W-1:0]  in_slot;
  logic [COL_W-1:0]   rd_col;
  logic [ROW_W-1:0]   rd_row;
  logic [SLOT_W-1:0]  rd_slot;
  logic [COL_W-1:0]   out_col;
  logic [LIN_W-1:0]   n_lin;
  logic [LIN_W-1:0]   q_lin;
  logic [LIN_W-1:0]   rd_lin;
  logic               owe;

  // pipeline
  col_req_t           s1;
  col_req_t           s1_next;
  win_req_t           s2;
  pix_t               ram_q [MAX_WINDOW];
  pix_t               wpix;
  pix_t               res;
  pix_t               out_pix;
  dp_cfg_t            dcfg;
  logic               adv;

  // step decode
  logic               complete;
  logic               in_col_last;
  logic               cmp_after;
  logic               acc;
  logic               wr;
  logic [LIN_W-1:0]   n_next;
  logic [LIN_W-1:0]   need;
  logic               rd_eq;
  logic               rd_lt;
  logic               want;
  logic               rd_go;
  logic               out_go;
  logic               eof_go;
  logic               owe_set;

  always_comb begin
    if (cfg_width == '0) begin
      w = (COL_W+1)'(1);
    end else if (cfg_width > (COL_W+1)'(MAX_WIDTH)) begin
      w = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w = cfg_width;
    end
    if (cfg_height == '0) begin
      h = ROW_W'(1);
    end else if (cfg_height > ROW_W'(MAX_ROWS)) begin
      h = ROW_W'(MAX_ROWS);
    end else begin
      h = cfg_height;
    end
    if (cfg_win[0]) begin
      kk = cfg_win;
    end else if (cfg_win == '0) begin
      kk = WIN_REG_W'(1);
    end else begin
      kk = cfg_win - WIN_REG_W'(1);
    end
    half = kk[WIN_REG_W-1:1];
    hw   = (half[0] ? LIN_W'(w) : '0) + (half[1] ? LIN_W'({w, 1'b0}) : '0);
    lag  = hw + LIN_W'(half);
  end

  assign dcfg = '{thresh: cfg_thresh, color: cfg_color, half: half, width: w};

  assign adv         = !(out_valid && out_stall && s2.out);
  assign complete    = (in_row >= h);
  assign in_col_last = (({1'b0, in_col} + (COL_W+1)'(1)) == w);
  assign cmp_after   = in_col_last && ((in_row + ROW_W'(1)) >= h);
  assign need        = q_lin + LIN_W'(half);
  assign rd_eq       = (rd_lin == need);
  assign rd_lt       = (rd_lin < need);
  assign in_stall    = !adv || settle || (complete && rd_lt) || owe;
  assign acc         = in_valid && !in_stall;
  assign wr          = acc && !complete && (operation == OP_PIXEL);
  assign n_next      = n_lin + LIN_W'(wr);

  always_comb begin
    rd_go   = 1'b0;
    out_go  = 1'b0;
    owe_set = 1'b0;
    want    = cmp_after || (n_next >= (q_lin + lag + LIN_W'(1)));
    if (acc && complete) begin
      rd_go  = 1'b1;
      out_go = 1'b1;
    end else if (wr) begin
      rd_go = ((rd_lin + hw) < n_next) || (cmp_after && !(rd_lin > need));
      if (want) begin
        if (rd_eq) out_go = 1'b1;
        else       owe_set = 1'b1;
      end
    end else if (adv && !settle && complete && rd_lt) begin
      // catch-up column read, input held
      rd_go = 1'b1;
    end else if (adv && !settle && owe && complete && rd_eq) begin
      rd_go  = 1'b1;
      out_go = 1'b1;
    end
    eof_go = out_go && (q_lin == total_m1);
  end

  assign wpix = {cfg_color ? sample_b : '0, cfg_color ? sample_g : '0, sample_r};

  // read request for the column at the read pointer, all window rows at once
  always_comb begin
    logic [SLOT_W+1:0]       sv;
    logic signed [ROW_W+1:0] r;
    s1_next         = '0;
    s1_next.rd      = rd_go;
    s1_next.out     = out_go;
    s1_next.eof     = eof_go;
    s1_next.ocol    = out_col;
    s1_next.fwd_pix = wpix;
    for (int o = 0; o < MAX_WINDOW; o++) begin
      sv = (SLOT_W+2)'(rd_slot) + (SLOT_W+2)'(o + MAX_WINDOW - CTR);
      if (sv >= (SLOT_W+2)'(2 * MAX_WINDOW)) begin
        sv = sv - (SLOT_W+2)'(2 * MAX_WINDOW);
      end else if (sv >= (SLOT_W+2)'(MAX_WINDOW)) begin
        sv = sv - (SLOT_W+2)'(MAX_WINDOW);
      end
      s1_next.slot[o]  = sv[SLOT_W-1:0];
      r                = $signed({2'b00, rd_row}) + $signed((ROW_W+2)'(o - CTR));
      s1_next.rowok[o] = (r >= 0) && (r < $signed({2'b00, h}));
      s1_next.fwd[o]   = wr && (sv[SLOT_W-1:0] == in_slot) && (rd_col == in_col);
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_row
    zcwe_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr && (in_slot == SLOT_W'(i))),
      .wr_addr (in_col),
      .wr_data (wpix),
      .rd_en   (rd_go),
      .rd_addr (rd_col),
      .rd_data (ram_q[i])
    );
  end

  zcwe_window u_window (
    .clk    (clk),
    .adv    (adv),
    .req    (s1),
    .ram_q  (ram_q),
    .cfg    (dcfg),
    .ocol   (s2.ocol),
    .result (res)
  );

  always_ff @(posedge clk) begin
    total_m1 <= LIN_W'(w) * LIN_W'(h) - LIN_W'(1);
    if (adv && s2.out) begin
      out_pix      <= res;
      end_of_frame <= s2.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= (COL_W+1)'(MAX_WIDTH);
      cfg_height <= ROW_W'(1024);
      cfg_win    <= WIN_REG_W'(3);
      cfg_thresh <= '0;
      cfg_color  <= 1'b1;
      settle     <= 1'b0;
      in_col     <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      rd_col     <= '0;
      rd_row     <= '0;
      rd_slot    <= '0;
      out_col    <= '0;
      n_lin      <= '0;
      q_lin      <= '0;
      rd_lin     <= '0;
      owe        <= 1'b0;
      s1         <= '0;
      s2         <= '0;
      out_valid  <= 1'b0;
    end else begin
      settle <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WIDTH:  cfg_width  <= cfg_data[COL_W:0];
          CFG_HEIGHT: cfg_height <= cfg_data[ROW_W-1:0];
          CFG_WINDOW: cfg_win    <= cfg_data[WIN_REG_W-1:0];
          CFG_THRESH: cfg_thresh <= cfg_data[THR_W-1:0];
          CFG_COLOR:  cfg_color  <= cfg_data[0];
          default: ;
        endcase
      end

      if (eof_go) begin
        // frame done: all position counters restart
        in_col  <= '0;
        in_row  <= '0;
        in_slot <= '0;
        rd_col  <= '0;
        rd_row  <= '0;
        rd_slot <= '0;
        out_col <= '0;
        n_lin   <= '0;
        q_lin   <= '0;
        rd_lin  <= '0;
        owe     <= 1'b0;
      end else begin
        if (wr) begin
          n_lin <= n_next;
          if (in_col_last) begin
            in_col  <= '0;
            in_row  <= in_row + ROW_W'(1);
            in_slot <= (in_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : in_slot + SLOT_W'(1);
          end else begin
            in_col <= in_col + COL_W'(1);
          end
        end
        if (rd_go) begin
          rd_lin <= rd_lin + LIN_W'(1);
          if (({1'b0, rd_col} + (COL_W+1)'(1)) == w) begin
            rd_col  <= '0;
            rd_row  <= rd_row + ROW_W'(1);
            rd_slot <= (rd_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : rd_slot + SLOT_W'(1);
          end else begin
            rd_col <= rd_col + COL_W'(1);
          end
        end
        if (out_go) begin
          q_lin <= q_lin + LIN_W'(1);
          if (({1'b0, out_col} + (COL_W+1)'(1)) == w) begin
            out_col <= '0;
          end else begin
            out_col <= out_col + COL_W'(1);
          end
        end
        if (owe_set) begin
          owe <= 1'b1;
        end else if (out_go) begin
          owe <= 1'b0;
        end
      end

      if (adv) begin
        s1 <= s1_next;
        s2 <= '{out: s1.out, eof: s1.eof, ocol: s1.ocol};
      end
      if (adv && s2.out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign edge_r = out_pix[0];
  assign edge_g = out_pix[1];
  assign edge_b = out_pix[2];

`ifndef SYNTHESIS
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    rd_lin <= need)
    else $error("read pointer ran past the window");

  a_owe_hold: assert property (@(posedge clk) disable iff (rst)
    owe |-> in_stall)
    else $error("word accepted while a result is owed");

  a_eof_clear: assert property (@(posedge clk) disable iff (rst)
    eof_go |=> (q_lin == '0 && rd_lin == '0 && n_lin == '0))
    else $error("counters not cleared after frame end");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (adv && s2.out) |=> out_valid)
    else $error("result lost at output register");

  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("word accepted right after a configuration write");
`endif

endmodule

// ===== dv/tb_zero_crossing_window_edge_core.sv =====
// Testbench for zero_crossing_window_edge_core: directed table, random frames, extreme sizes.
// Depends on zcwe_pkg and the core RTL; results checked against an in-bench window predictor.
`timescale 1ns / 1ps

module tb_zero_crossing_window_edge_core;
  import zcwe_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int RAND_WORDS   = 400;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       eof;
  } edge_word_t;

  typedef struct {
    bit         is_cfg;
    cfg_idx_t   idx;
    int         val;
    op_t        op;
    logic [7:0] r, g, b;
    bit         typed;
    edge_word_t exp_word;
  } stim_row_t;

  logic clk, rst;
  logic in_valid, in_stall, operation;
  logic [7:0] sample_r, sample_g, sample_b;
  logic out_valid, out_stall;
  logic [7:0] edge_r, edge_g, edge_b;
  logic end_of_frame;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  zero_crossing_window_edge_core DUT (.*);

  // predictor state
  int cur_width, cur_height, cur_win, cur_thresh, cur_color;
  logic [23:0] row_mem [MAX_WINDOW*MAX_WIDTH];
  int in_col, in_row, out_col, out_row;
  bit frame_done;

  edge_word_t edge_q[$];
  int errors, cycles, idle_mode;
  bit hold_req, hold_done;
  int hold_cnt;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // long receiver hold, requested once by the stimulus
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      hold_cnt <= 400;
      hold_done <= 1'b1;
    end
  end

  // result side: check and stall generation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (edge_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word r=%0d g=%0d b=%0d eof=%0b",
                                   edge_r, edge_g, edge_b, end_of_frame);
      end else begin
        edge_word_t e;
        e = edge_q.pop_front();
        if (e !== {edge_r, edge_g, edge_b, end_of_frame}) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp r=%0d g=%0d b=%0d eof=%0b got r=%0d g=%0d b=%0d eof=%0b",
                     e.r, e.g, e.b, e.eof, edge_r, edge_g, edge_b, end_of_frame);
        end
      end
    end
    if (hold_cnt > 0 || (hold_req && !hold_done)) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= (idle_mode == 2 && $urandom_range(0, 99) < 54) ||
                   (idle_mode == 3 && $urandom_range(0, 99) < 6);
    end
  end

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // one accepted word into the window model; got=1 when it yields a result
  task automatic edge_step(input op_t op, input logic [7:0] sr, sg, sb,
                           output bit got, output edge_word_t res);
    int w, h, k, half, total, n, q, r, c, lo, hi, ctr, v;
    bit complete;
    logic [23:0] px;
    got = 0;
    res = '0;
    w = clampi(cur_width, 1, MAX_WIDTH);
    h = clampi(cur_height, 1, MAX_ROWS);
    k = cur_win;
    if (k % 2 == 0) k = (k == 0) ? 1 : k - 1;
    k = clampi(k, 1, MAX_WINDOW);
    half = k / 2;
    total = w * h;
    if (in_col >= w) begin in_col = 0; in_row++; end
    if (out_col >= w) begin out_col = 0; out_row++; end
    if (in_row >= h) begin in_row = h; in_col = 0; end
    if (out_row >= h) begin in_col = 0; in_row = 0; out_col = 0; out_row = 0; end
    complete = in_row >= h;
    if (!complete && op == OP_PIXEL) begin
      px = cur_color ? {sb, sg, sr} : {16'd0, sr};
      row_mem[(in_row % MAX_WINDOW) * MAX_WIDTH + in_col] = px;
      in_col++;
      if (in_col >= w) begin in_col = 0; in_row++; end
      complete = in_row >= h;
    end else if (!complete) begin
      return;
    end
    n = complete ? total : in_row * w + in_col;
    q = out_row * w + out_col;
    if (!complete && n < q + half * w + half + 1) return;
    for (int ch = 0; ch < (cur_color ? 3 : 1); ch++) begin
      lo = 255; hi = 0; ctr = 0;
      for (int dy = 0; dy < k; dy++)
        for (int dx = 0; dx < k; dx++) begin
          r = out_row + dy - half;
          c = out_col + dx - half;
          v = 0;
          if (r >= 0 && r < h && c >= 0 && c < w)
            v = (row_mem[(r % MAX_WINDOW) * MAX_WIDTH + c] >> (8 * ch)) & 8'hFF;
          if (dy == half && dx == half) ctr = v;
          if (v < lo) lo = v;
          if (v > hi) hi = v;
        end
      if (lo < BIAS - cur_thresh && hi > BIAS + cur_thresh) begin
        if (ch == 0) res.r = ctr;
        else if (ch == 1) res.g = ctr;
        else res.b = ctr;
      end
    end
    res.eof = (q == total - 1);
    got = 1;
    out_col++;
    if (out_col >= w) begin out_col = 0; out_row++; end
    if (res.eof) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      frame_done = 1;
    end
  endtask

  task automatic send_word(input op_t op, input logic [7:0] sr, sg, sb,
                           output bit got, output edge_word_t res);
    if ((idle_mode == 1 && $urandom_range(0, 99) < 54) ||
        (idle_mode == 3 && $urandom_range(0, 99) < 6)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    sample_r <= sr;
    sample_g <= sg;
    sample_b <= sb;
    do @(posedge clk); while (in_stall);
    edge_step(op, sr, sg, sb, got, res);
  endtask

  task automatic push_word(input op_t op, input logic [7:0] sr, sg, sb);
    bit got;
    edge_word_t res;
    send_word(op, sr, sg, sb, got, res);
    if (got) edge_q.push_back(res);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input cfg_idx_t idx, input int val);
    in_valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_WIDTH:  cur_width  = val & 11'h7FF;
      CFG_HEIGHT: cur_height = val & 13'h1FFF;
      CFG_WINDOW: cur_win    = val & 3'h7;
      CFG_THRESH: cur_thresh = val & 8'hFF;
      CFG_COLOR:  cur_color  = val & 1'b1;
      default: ;
    endcase
  endtask

  // full frame of random pixels, a few early flushes, then drain to end of frame
  task automatic run_frame(output int words);
    int npix;
    npix = clampi(cur_width, 1, MAX_WIDTH) * clampi(cur_height, 1, MAX_ROWS);
    frame_done = 0;
    words = 0;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 19) == 0) push_word(OP_FLUSH, $urandom, $urandom, $urandom);
      push_word(OP_PIXEL, $urandom, $urandom, $urandom);
      words++;
    end
    while (!frame_done) begin
      push_word($urandom_range(0, 4) == 0 ? OP_PIXEL : OP_FLUSH,
                $urandom, $urandom, $urandom);
      words++;
    end
  endtask

  stim_row_t dir_tab[] = '{
    '{1, CFG_WIDTH,  1, OP_PIXEL, 0, 0, 0, 0, '0},
    '{1, CFG_HEIGHT, 1, OP_PIXEL, 0, 0, 0, 0, '0},
    '{1, CFG_WINDOW, 1, OP_PIXEL, 0, 0, 0, 0, '0},
    '{1, CFG_THRESH, 0, OP_PIXEL, 0, 0, 0, 0, '0},
    '{1, CFG_COLOR,  1, OP_PIXEL, 0, 0, 0, 0, '0},
    // early flush on an empty frame: nothing comes out
    '{0, CFG_WIDTH, 0, OP_FLUSH, 8'd9, 8'd9, 8'd9, 0, '0},
    // 1x1 frame, 1x1 window: min equals max, never a crossing
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd255, 8'd0, 8'd128, 1, '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd0, 8'd255, 8'd1, 1, '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{1, CFG_WIDTH,  3, OP_PIXEL, 0, 0, 0, 0, '0},
    '{1, CFG_HEIGHT, 2, OP_PIXEL, 0, 0, 0, 0, '0},
    '{1, CFG_WINDOW, 3, OP_PIXEL, 0, 0, 0, 0, '0},
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd255, 8'd0, 8'd200, 0, '0},
    '{0, CFG_WIDTH, 0, OP_FLUSH, 8'd0, 8'd0, 8'd0, 0, '0},
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd0, 8'd255, 8'd10, 0, '0},
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd129, 8'd127, 8'd128, 0, '0},
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd200, 8'd50, 8'd255, 0, '0},
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd127, 8'd129, 8'd0, 0, '0},
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd170, 8'd85, 8'd255, 0, '0},
    // frame already complete: a pixel acts as a flush
    '{0, CFG_WIDTH, 0, OP_PIXEL, 8'd1, 8'd2, 8'd3, 0, '0},
    '{0, CFG_WIDTH, 0, OP_FLUSH, 8'd0, 8'd0, 8'd0, 0, '0},
    '{0, CFG_WIDTH, 0, OP_FLUSH, 8'd0, 8'd0, 8'd0, 0, '0},
    '{0, CFG_WIDTH, 0, OP_FLUSH, 8'd0, 8'd0, 8'd0, 0, '0},
    '{1, CFG_COLOR,  0, OP_PIXEL, 0, 0, 0, 0, '0},
    '{1, CFG_THRESH, 255, OP_PIXEL, 0, 0, 0, 0, '0}
  };

  initial begin
    int words, total_words;
    bit got;
    edge_word_t res;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_PIXEL;
    sample_r = '0; sample_g = '0; sample_b = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    errors = 0; cycles = 0; idle_mode = 0;
    hold_req = 0; hold_done = 0; hold_cnt = 0;
    cur_width = 1024; cur_height = 1024; cur_win = 3; cur_thresh = 0; cur_color = 1;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_word(dir_tab[i].op, dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, got, res);
        if (got) edge_q.push_back(dir_tab[i].typed ? dir_tab[i].exp_word : res);
      end
    end

    total_words = 0;
    while (total_words < RAND_WORDS) begin
      idle_mode = (total_words * 4 / RAND_WORDS) % 4;
      if ($urandom_range(0, 2) == 0 || total_words == 0) begin
        write_reg(CFG_WIDTH, $urandom_range(0, 9) == 0 ? $urandom_range(13, 64)
                                                      : $urandom_range(1, 12));
        write_reg(CFG_HEIGHT, $urandom_range(1, 8));
        write_reg(CFG_WINDOW, $urandom_range(1, 7));
        case ($urandom_range(0, 3))
          0: write_reg(CFG_THRESH, 0);
          1: write_reg(CFG_THRESH, 255);
          default: write_reg(CFG_THRESH, $urandom_range(0, 60));
        endcase
        write_reg(CFG_COLOR, $urandom_range(0, 1));
      end
      // sender keeps offering this frame while the receiver holds off
      if (idle_mode == 0 && cur_width * cur_height >= 16) hold_req = 1;
      run_frame(words);
      total_words += words;
    end

    // widest line, then a tall single column with an even window value
    idle_mode = 0;
    write_reg(CFG_THRESH, 10);
    write_reg(CFG_COLOR, 1);
    write_reg(CFG_WINDOW, 7);
    write_reg(CFG_WIDTH, 1024);
    write_reg(CFG_HEIGHT, 1);
    run_frame(words);
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 64);
    write_reg(CFG_WINDOW, 6);
    run_frame(words);

    in_valid <= 1'b0;
    while (edge_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
